// ===== hdl/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants for the descending record sorter.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int RANK_BITS     = 6;
  localparam int LIMIT_BITS    = 7;
  localparam int MAX_EMIT      = 64;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(50);

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_KEEP_LIMIT = 1'b0
  } reg_index_t;

  // zero counts as one, anything above the emit ceiling is capped
  function automatic logic [LIMIT_BITS-1:0] clamp_limit(input logic [LIMIT_BITS-1:0] v);
    logic [LIMIT_BITS-1:0] r;
    r = v;
    if (v == '0) begin
      r = LIMIT_BITS'(1);
    end else if (v > LIMIT_BITS'(MAX_EMIT)) begin
      r = LIMIT_BITS'(MAX_EMIT);
    end
    return r;
  endfunction

endpackage

// ===== hdl/dsr_store.sv =====
// ----------------------------------------------------------------------------
// dsr_store
// Simple dual-port record memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsr_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dsr_engine.sv =====
// ----------------------------------------------------------------------------
// dsr_engine
// Load sequencer, in-memory bubble sort passes and result emitter.
// ----------------------------------------------------------------------------
module dsr_engine #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 24,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dsr_pkg::LIMIT_BITS-1:0] keep_limit,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [KEY_BITS-1:0]           score_key,
  input  logic [TAG_BITS-1:0]           record_tag,
  input  logic                          last_record,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [KEY_BITS-1:0]           out_score,
  output logic [TAG_BITS-1:0]           out_tag,
  output logic [dsr_pkg::RANK_BITS-1:0] out_rank,
  output logic                          out_last,
  output logic                          overflow_seen
);

  import dsr_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KEY_BITS + TAG_BITS;
  localparam int NW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  typedef enum logic [6:0] {
    S_LOAD       = 7'b0000001,
    S_PASS_START = 7'b0000010,
    S_PASS_FIRST = 7'b0000100,
    S_PASS_RUN   = 7'b0001000,
    S_PASS_END   = 7'b0010000,
    S_EMIT_RD    = 7'b0100000,
    S_EMIT_LD    = 7'b1000000
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic            drop;
  logic [AW-1:0]   m;
  logic [AW-1:0]   j;
  logic [AW-1:0]   k;
  logic [DW-1:0]   carry;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [DW-1:0]   mem_rdata;

  logic            full;
  logic            in_fire;
  logic            out_free;
  logic            carry_less;
  logic [LIMIT_BITS-1:0] lim;
  logic [NW-1:0]   ne;
  logic            k_is_last;

  dsr_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign full       = (cnt == CW'(CAPACITY));
  assign in_ready   = (state == S_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  // strict less-than keeps equal keys in arrival order
  assign carry_less = carry[DW-1:TAG_BITS] < mem_rdata[DW-1:TAG_BITS];
  assign lim        = clamp_limit(keep_limit);
  assign ne         = (NW'(cnt) < NW'(lim)) ? NW'(cnt) : NW'(lim);
  assign k_is_last  = (NW'(k) == ne - NW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_LOAD: begin
        mem_we    = in_fire && !full;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = {score_key, record_tag};
      end
      S_PASS_START: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_PASS_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_PASS_RUN: begin
        // the smaller record stays in carry and moves on to the right
        mem_we    = 1'b1;
        mem_waddr = j - AW'(1);
        mem_wdata = carry_less ? mem_rdata : carry;
        mem_re    = (j != m);
        mem_raddr = j + AW'(1);
      end
      S_PASS_END: begin
        mem_we    = 1'b1;
        mem_waddr = m;
        mem_wdata = carry;
      end
      S_EMIT_RD: begin
        mem_re    = out_free;
        mem_raddr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      cnt       <= '0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (full) begin
              drop <= 1'b1;
            end else begin
              cnt <= cnt + CW'(1);
            end
            if (last_record) begin
              if (cnt == '0) begin
                state <= S_EMIT_RD;
              end else begin
                state <= S_PASS_START;
              end
            end
          end
        end
        S_PASS_START: state <= S_PASS_FIRST;
        S_PASS_FIRST: state <= S_PASS_RUN;
        S_PASS_RUN: begin
          if (j == m) begin
            state <= S_PASS_END;
          end
        end
        S_PASS_END: begin
          if (m == AW'(1)) begin
            state <= S_EMIT_RD;
          end else begin
            state <= S_PASS_START;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          if (k_is_last) begin
            cnt   <= '0;
            drop  <= 1'b0;
            state <= S_LOAD;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // sort and emit indices, carry and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        k <= '0;
        m <= full ? AW'(cnt - CW'(1)) : AW'(cnt);
      end
      S_PASS_FIRST: begin
        carry <= mem_rdata;
        j     <= AW'(1);
      end
      S_PASS_RUN: begin
        if (!carry_less) begin
          carry <= mem_rdata;
        end
        if (j != m) begin
          j <= j + AW'(1);
        end
      end
      S_PASS_END: begin
        m <= m - AW'(1);
      end
      S_EMIT_LD: begin
        out_score     <= mem_rdata[DW-1:TAG_BITS];
        out_tag       <= mem_rdata[TAG_BITS-1:0];
        out_rank      <= RANK_BITS'(k);
        out_last      <= k_is_last;
        overflow_seen <= drop;
        k             <= k + AW'(1);
      end
      default: begin
      end
    endcase
  end

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("record store read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  a_pass_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS_RUN) |-> (j != '0 && j <= m))
    else $error("sort pass index outside the pass");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD) |-> (NW'(k) < ne))
    else $error("emit index beyond output count");

endmodule

// ===== hdl/descending_record_sorter.sv =====
// Loading: one record beat per cycle. After the beat marked last, the n stored records
// go through sort passes over the record memory (one read and one write a cycle),
// then each result is read when the output is free and registered onto the outputs.
// Throughput: one set at a time; the next set loads while the final result waits.
// Reset: clears count, drop flag, handshake state; keep_limit returns to 50.
// The record memory is not cleared; only entries written in the current set are read.
// ----------------------------------------------------------------------------
// descending_record_sorter
// Collects scored records, sorts them best first and emits the top entries.
// ----------------------------------------------------------------------------
module descending_record_sorter #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 24,
  parameter int TAG_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dsr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [dsr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [dsr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [KEY_BITS-1:0]              score_key,
  input  logic [TAG_BITS-1:0]              record_tag,
  input  logic                             last_record,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [KEY_BITS-1:0]              out_score,
  output logic [TAG_BITS-1:0]              out_tag,
  output logic [dsr_pkg::RANK_BITS-1:0]    out_rank,
  output logic                             out_last,
  output logic                             overflow_seen
);

  import dsr_pkg::*;

  logic [LIMIT_BITS-1:0] keep_limit;
  reg_index_t            reg_sel;
  logic                  reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_BITS-1]);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == REG_KEEP_LIMIT) ? APB_DATA_BITS'(keep_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= LIMIT_RESET;
    end else if (reg_wr && reg_sel == REG_KEEP_LIMIT) begin
      keep_limit <= pwdata[LIMIT_BITS-1:0];
    end
  end

  dsr_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .keep_limit    (keep_limit),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .score_key     (score_key),
    .record_tag    (record_tag),
    .last_record   (last_record),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_score     (out_score),
    .out_tag       (out_tag),
    .out_rank      (out_rank),
    .out_last      (out_last),
    .overflow_seen (overflow_seen)
  );

endmodule
